/* hdl/key_set_table_core_defines.svh */
// ----------------------------------------------------------------------------
// key_set_table_core_defines
// assertion macros for the key set table rtl
// ----------------------------------------------------------------------------
`ifndef KEY_SET_TABLE_CORE_DEFINES_SVH
`define KEY_SET_TABLE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define KST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/kst_pkg.sv */
// ----------------------------------------------------------------------------
// kst_pkg
// types, codes and defaults for the key set table
// ----------------------------------------------------------------------------
package kst_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_BITS_DEF = 48;

   localparam int MODE_BITS   = 2;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 7;

   localparam logic [MODE_BITS-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_QUERY  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ERR = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_YES = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_NO  = 2'd3;

   typedef enum logic {
      STATE_IDLE,
      STATE_SEARCH
   } state_type;

   // search token passed from cell to cell
   typedef struct packed {
      logic active;
      logic found;
      logic placed;
   } wave_type;

   // operation broadcast to every cell
   typedef struct packed {
      logic do_add;
      logic do_remove;
   } cmd_type;

endpackage

/* hdl/kst_cell.sv */
// ----------------------------------------------------------------------------
// kst_cell
// one table slot: holds a key and its valid bit, handles the passing token
// ----------------------------------------------------------------------------
module kst_cell #(
   parameter int KEY_BITS = kst_pkg::KEY_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  kst_pkg::cmd_type    cmd,
   input  logic [KEY_BITS-1:0] req_key,
   input  kst_pkg::wave_type   wave_prev,
   input  logic [KEY_BITS-1:0] next_key,
   input  logic                next_valid,
   output kst_pkg::wave_type   wave_next,
   output logic [KEY_BITS-1:0] cell_key,
   output logic                cell_valid
);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                valid_ff, valid_in;
   kst_pkg::wave_type   wave_ff, wave_in;
   logic                match;
   logic                hit;
   logic                take_add;
   logic                take_shift;

   always_comb begin
      match      = valid_ff && (key_ff == req_key);
      hit        = wave_prev.found || match;
      // entries are packed low, so the first empty slot sees the final found flag
      take_add   = wave_prev.active && cmd.do_add && !valid_ff &&
                   !wave_prev.found && !wave_prev.placed;
      take_shift = wave_prev.active && cmd.do_remove && hit;

      key_in   = key_ff;
      valid_in = valid_ff;
      if (take_add) begin
         key_in   = req_key;
         valid_in = 1'b1;
      end else if (take_shift) begin
         key_in   = next_key;
         valid_in = next_valid;
      end

      wave_in.active = wave_prev.active;
      wave_in.found  = wave_prev.active && hit;
      wave_in.placed = wave_prev.active && (wave_prev.placed || take_add);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         wave_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         wave_ff  <= wave_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign wave_next  = wave_ff;
   assign cell_key   = key_ff;
   assign cell_valid = valid_ff;

endmodule

/* hdl/key_set_table_core.sv */
// the search token goes from the launch register through every cell register,
//   walking the cell chain one slot per cycle, and the result strobe is registered
//   once it leaves the last cell; no new request is taken until the result is shown
// busy is low again in the cycle the result strobe is shown
// reset clears the entry count, all valid bits and the strobe; keys are kept
// the result is shown for one cycle only and cannot be held off
// ----------------------------------------------------------------------------
// key_set_table_core
// ordered set of unique keys held in a chain of cells with add, remove, query
// ----------------------------------------------------------------------------
`include "key_set_table_core_defines.svh"

module key_set_table_core #(
   parameter int CAPACITY = kst_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = kst_pkg::KEY_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [kst_pkg::MODE_BITS-1:0]      req_mode,
   input  logic [KEY_BITS-1:0]                req_key,
   output logic                               rsp_strobe,
   output logic [kst_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [kst_pkg::COUNT_BITS-1:0]     rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   kst_pkg::state_type                 state_ff, state_in;
   logic [kst_pkg::MODE_BITS-1:0]      mode_ff, mode_in;
   logic [KEY_BITS-1:0]                key_ff, key_in;
   kst_pkg::wave_type                  launch_ff, launch_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic                               strobe_ff, strobe_in;
   logic [kst_pkg::STATUS_BITS-1:0]    status_ff, status_in;

   kst_pkg::cmd_type                   cmd;
   kst_pkg::wave_type                  wave [CAPACITY+1];
   logic [KEY_BITS-1:0]                cell_keys [CAPACITY];
   logic [CAPACITY-1:0]                valid_vec;
   kst_pkg::wave_type                  tail;
   logic                               accept;
   logic [CNT_W+kst_pkg::COUNT_BITS-1:0] count_ext;

   assign cmd.do_add    = (mode_ff == kst_pkg::MODE_ADD);
   assign cmd.do_remove = (mode_ff == kst_pkg::MODE_REMOVE);
   assign wave[0]       = launch_ff;
   assign tail          = wave[CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_BITS-1:0] nkey;
      logic                nvalid;
      if (i == CAPACITY - 1) begin : g_last
         assign nkey   = '0;
         assign nvalid = 1'b0;
      end else begin : g_mid
         assign nkey   = cell_keys[i+1];
         assign nvalid = valid_vec[i+1];
      end
      kst_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .req_key    (key_ff),
         .wave_prev  (wave[i]),
         .next_key   (nkey),
         .next_valid (nvalid),
         .wave_next  (wave[i+1]),
         .cell_key   (cell_keys[i]),
         .cell_valid (valid_vec[i])
      );
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      key_in    = key_ff;
      launch_in = '0;
      count_in  = count_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      accept    = 1'b0;
      busy      = 1'b1;

      case (state_ff)
         kst_pkg::STATE_IDLE: begin
            busy = 1'b0;
            if (start) begin
               accept           = 1'b1;
               mode_in          = req_mode;
               key_in           = req_key;
               launch_in.active = 1'b1;
               state_in         = kst_pkg::STATE_SEARCH;
            end
         end
         kst_pkg::STATE_SEARCH: begin
            if (tail.active) begin
               strobe_in = 1'b1;
               state_in  = kst_pkg::STATE_IDLE;
               status_in = kst_pkg::STATUS_ERR;
               case (mode_ff)
                  kst_pkg::MODE_ADD: begin
                     if (tail.placed) begin
                        status_in = kst_pkg::STATUS_OK;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  kst_pkg::MODE_REMOVE: begin
                     if (tail.found) begin
                        status_in = kst_pkg::STATUS_OK;
                        count_in  = count_ff - CNT_W'(1);
                     end
                  end
                  kst_pkg::MODE_QUERY: begin
                     status_in = tail.found ? kst_pkg::STATUS_YES : kst_pkg::STATUS_NO;
                  end
                  default: begin
                     status_in = kst_pkg::STATUS_ERR;
                  end
               endcase
            end
         end
         default: begin
            state_in = kst_pkg::STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= kst_pkg::STATE_IDLE;
         launch_ff <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      status_ff <= status_in;
   end

   assign count_ext       = {{kst_pkg::COUNT_BITS{1'b0}}, count_ff};
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ext[kst_pkg::COUNT_BITS-1:0];

   `KST_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy,
      "request accepted but block not busy")
   `KST_ASSERT_NEXT(a_tail_strobe, clock, reset, tail.active, rsp_strobe && !busy,
      "token left chain without a result")
   `KST_ASSERT_NOW(a_count_valid, clock, reset, !busy,
      CNT_W'($countones(valid_vec)) == count_ff, "entry count disagrees with valid cells")
   `KST_ASSERT_NOW(a_packed, clock, reset, !busy,
      ((valid_vec + CAPACITY'(1)) & valid_vec) == '0, "valid entries not packed low")

endmodule

/* dv/tb_key_set_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_set_table_core
// drives add, remove, query and unused-mode requests into the key set table and checks
// every response against a queue-based shadow of the table: directed corner
// cases first, then a fill to capacity and drain, then random churn with
// bursty request pacing
// ----------------------------------------------------------------------------
module tb_key_set_table_core;

   localparam int CAPACITY    = kst_pkg::CAPACITY_DEF;
   localparam int KEY_BITS    = kst_pkg::KEY_BITS_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int POOL_SIZE   = 96;

   // mode code with no operation behind it
   localparam logic [kst_pkg::MODE_BITS-1:0] MODE_UNUSED = 2'd3;

   typedef logic [KEY_BITS-1:0] key_type;

   typedef struct packed {
      logic [kst_pkg::STATUS_BITS-1:0] status;
      logic [kst_pkg::COUNT_BITS-1:0]  count;
   } outcome_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [kst_pkg::MODE_BITS-1:0]   req_mode = kst_pkg::MODE_QUERY;
   key_type                         req_key = '0;
   logic                            rsp_strobe;
   logic [kst_pkg::STATUS_BITS-1:0] rsp_status;
   logic [kst_pkg::COUNT_BITS-1:0]  rsp_entry_count;

   key_type     shadow_keys[$];
   outcome_type pending_outcomes[$];
   key_type     key_pool[POOL_SIZE];
   int          error_count = 0;
   int          burst_left = 0;
   int          stall_cycles = 0;

   key_set_table_core #(
      .CAPACITY(CAPACITY),
      .KEY_BITS(KEY_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_key(req_key),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

   always #1 clock = ~clock;

   function automatic int find_slot(input key_type key);
      foreach (shadow_keys[i]) begin
         if (shadow_keys[i] == key) return i;
      end
      return -1;
   endfunction

   // applies one request to the shadow table and gives the response it causes
   function automatic outcome_type predict_outcome(input logic [kst_pkg::MODE_BITS-1:0] mode,
                                                   input key_type key);
      outcome_type result;
      int          slot;
      slot = find_slot(key);
      result.status = kst_pkg::STATUS_ERR;
      case (mode)
         kst_pkg::MODE_ADD: begin
            if (slot < 0 && shadow_keys.size() < CAPACITY) begin
               shadow_keys.push_back(key);
               result.status = kst_pkg::STATUS_OK;
            end
         end
         kst_pkg::MODE_REMOVE: begin
            if (slot >= 0) begin
               shadow_keys.delete(slot);
               result.status = kst_pkg::STATUS_OK;
            end
         end
         kst_pkg::MODE_QUERY:
            result.status = (slot >= 0) ? kst_pkg::STATUS_YES : kst_pkg::STATUS_NO;
         default: ;
      endcase
      result.count = kst_pkg::COUNT_BITS'(shadow_keys.size());
      return result;
   endfunction

   function automatic key_type random_key();
      return KEY_BITS'({$urandom(), $urandom()});
   endfunction

   function automatic key_type held_key();
      return shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
   endfunction

   // bursts of requests separated by gaps of random length
   task automatic pace_requests();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         case ($urandom_range(0, 3))
            0: gap = 0;
            1: gap = $urandom_range(1, 8);
            2: gap = $urandom_range(9, CAPACITY + 16);
            default: gap = $urandom_range(CAPACITY, 3 * CAPACITY);
         endcase
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic issue_request(input logic [kst_pkg::MODE_BITS-1:0] mode, input key_type key);
      pace_requests();
      start    <= 1'b1;
      req_mode <= mode;
      req_key  <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_outcomes.push_back(predict_outcome(mode, key));
   endtask

   task automatic test_basic_operations();
      key_type ones;
      key_type alt_a;
      key_type alt_5;
      key_type top_bit;
      ones    = '1;
      alt_a   = {(KEY_BITS / 2){2'b10}};
      alt_5   = {(KEY_BITS / 2){2'b01}};
      top_bit = key_type'(1) << (KEY_BITS - 1);
      issue_request(kst_pkg::MODE_QUERY, '0);      // query on empty table
      issue_request(kst_pkg::MODE_REMOVE, '0);     // remove from empty table
      issue_request(kst_pkg::MODE_ADD, '0);
      issue_request(kst_pkg::MODE_ADD, ones);
      issue_request(kst_pkg::MODE_ADD, '0);        // duplicate
      issue_request(kst_pkg::MODE_QUERY, ones);
      issue_request(kst_pkg::MODE_QUERY, key_type'(1));
      issue_request(kst_pkg::MODE_ADD, alt_a);
      issue_request(kst_pkg::MODE_ADD, alt_5);
      issue_request(kst_pkg::MODE_REMOVE, ones);   // middle entry, later ones shift down
      issue_request(kst_pkg::MODE_QUERY, alt_5);
      issue_request(kst_pkg::MODE_REMOVE, ones);   // already gone
      issue_request(MODE_UNUSED, '0);
      issue_request(MODE_UNUSED, alt_5);
      issue_request(kst_pkg::MODE_ADD, top_bit);
      issue_request(kst_pkg::MODE_QUERY, top_bit);
      issue_request(kst_pkg::MODE_REMOVE, '0);     // first entry
      issue_request(kst_pkg::MODE_REMOVE, top_bit); // last entry
      issue_request(kst_pkg::MODE_REMOVE, alt_a);
      issue_request(kst_pkg::MODE_REMOVE, alt_5);
      issue_request(kst_pkg::MODE_QUERY, alt_a);
      issue_request(kst_pkg::MODE_ADD, ones);
   endtask

   task automatic test_fill_and_drain();
      key_type probe;
      while (shadow_keys.size() < CAPACITY) issue_request(kst_pkg::MODE_ADD, random_key());
      probe = random_key();
      issue_request(kst_pkg::MODE_ADD, probe);     // table full
      issue_request(kst_pkg::MODE_ADD, held_key()); // duplicate while full
      issue_request(kst_pkg::MODE_QUERY, shadow_keys[CAPACITY - 1]);
      issue_request(kst_pkg::MODE_QUERY, probe);
      issue_request(kst_pkg::MODE_REMOVE, shadow_keys[0]);
      issue_request(kst_pkg::MODE_ADD, probe);     // room again, lands at the end
      issue_request(kst_pkg::MODE_REMOVE, shadow_keys[shadow_keys.size() - 1]);
      issue_request(kst_pkg::MODE_REMOVE, shadow_keys[CAPACITY / 2]);
      while (shadow_keys.size() > 0) begin
         if ($urandom_range(0, 3) == 0) issue_request(kst_pkg::MODE_QUERY, held_key());
         issue_request(kst_pkg::MODE_REMOVE, held_key());
      end
   endtask

   task automatic test_random_churn(input int phases, input int per_phase);
      int                            add_weight;
      int                            roll;
      logic [kst_pkg::MODE_BITS-1:0] mode;
      key_type                       key;
      key_pool[0] = random_key();
      for (int n = 1; n < POOL_SIZE; n++) begin
         // the first part of the pool differs from one base key by one bit
         key_pool[n] = (n < 24) ?
                       (key_pool[0] ^ (key_type'(1) << $urandom_range(0, KEY_BITS - 1))) :
                       random_key();
      end
      for (int p = 0; p < phases; p++) begin
         case (p % 3)
            0: add_weight = 85;
            1: add_weight = 50;
            default: add_weight = 20;
         endcase
         for (int i = 0; i < per_phase; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) mode = MODE_UNUSED;
            else if ($urandom_range(0, 99) < add_weight) mode = kst_pkg::MODE_ADD;
            else if ($urandom_range(0, 9) < 6) mode = kst_pkg::MODE_REMOVE;
            else mode = kst_pkg::MODE_QUERY;
            roll = $urandom_range(0, 99);
            if (mode == kst_pkg::MODE_ADD)
               key = (roll < 70) ? key_pool[$urandom_range(0, POOL_SIZE - 1)] :
                     (roll < 90 || shadow_keys.size() == 0) ? random_key() : held_key();
            else if (roll < 60 && shadow_keys.size() > 0)
               key = held_key();
            else
               key = (roll < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)] : random_key();
            issue_request(mode, key);
         end
      end
   endtask

   always @(posedge clock) begin : check_responses
      outcome_type want;
      if (!reset && rsp_strobe) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: response with none expected, status %0d count %0d",
                     $time, rsp_status, rsp_entry_count);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_entry_count !== want.count) begin
               $display("%0t: entry count expected %0d actual %0d",
                        $time, want.count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   // ends the run when neither a request nor a response moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, %0d responses outstanding", $time, pending_outcomes.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_operations();
      test_fill_and_drain();
      test_random_churn(12, 115);
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* key_set_table_core.f */
+incdir+hdl
hdl/kst_pkg.sv
hdl/kst_cell.sv
hdl/key_set_table_core.sv
dv/tb_key_set_table_core.sv
